>>> design/pds_pkg.sv
// Shared widths and control/status types for the proper divisor sum block.
package pds_pkg;

   // Width of the number examined.
   localparam int NUMBER_WIDTH = 16;
   // Width of the reported divisor sum.
   localparam int SUM_WIDTH    = 18;
   // Accumulator width: at least the reported width; the aliquot sum stays below
   // eight times the number for every width up to 32 bits.
   localparam int ACC_WIDTH    = (NUMBER_WIDTH + 3 > SUM_WIDTH) ? NUMBER_WIDTH + 3 : SUM_WIDTH;
   // Step counter of the serial remainder unit.
   localparam int STEP_WIDTH   = $clog2(NUMBER_WIDTH) + 1;

   // Command from the sequencer to the remainder unit.
   typedef struct packed {
      logic start;
   } rem_ctrl_type;

   // Status from the remainder unit to the sequencer.
   typedef struct packed {
      logic done;
      logic is_zero;
   } rem_status_type;

endpackage

>>> design/pds_rem_unit.sv
// Serial restoring remainder unit: one dividend bit per cycle.
module pds_rem_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pds_pkg::rem_ctrl_type                 ctrl,
   input  logic [pds_pkg::NUMBER_WIDTH-1:0]      dividend,
   input  logic [pds_pkg::NUMBER_WIDTH-1:0]      divisor,
   output pds_pkg::rem_status_type               status
);
   import pds_pkg::*;

   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(NUMBER_WIDTH - 1);

   logic                    run_ff,  run_in;
   logic                    done_ff, done_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   logic [NUMBER_WIDTH-1:0] rem_ff,  rem_in;
   logic [NUMBER_WIDTH-1:0] shift_ff, shift_in;
   logic [NUMBER_WIDTH-1:0] divisor_ff, divisor_in;
   logic [NUMBER_WIDTH:0]   trial;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      run_in     = run_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      trial      = {rem_ff, shift_ff[NUMBER_WIDTH-1]};
      if (ctrl.start) begin
         run_in     = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         shift_in   = dividend;
         divisor_in = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = NUMBER_WIDTH'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[NUMBER_WIDTH-1:0];
         end
         shift_in = {shift_ff[NUMBER_WIDTH-2:0], 1'b0};
         step_in  = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state and the partial remainder with reset; shift and divisor registers without.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         rem_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
         rem_ff  <= rem_in;
      end
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
   end

   assign status.done    = done_ff;
   assign status.is_zero = (rem_ff == '0);

   // The partial remainder stays below a nonzero divisor while running.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (run_ff && !$past(ctrl.start) && divisor_ff != '0) |-> (rem_ff < divisor_ff))
      else $error("partial remainder not below divisor");

   // The last step raises done in the next cycle and stops the unit.
   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (run_ff && !ctrl.start && step_ff == LAST_STEP) |=> (done_ff && !run_ff))
      else $error("remainder unit did not finish after last step");

   // Done is a single pulse that never overlaps running.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff)
      else $error("done raised while running");

endmodule

>>> design/proper_divisor_sum.sv
// Top level: sequencer that sums proper divisors using the shared remainder unit.
//
// Takes one 16-bit number per item when start is high and busy is low, and
// returns the sum of its proper divisors and a perfect-number flag on a
// one-cycle rsp_valid strobe; the receiver cannot stall, so the result must be
// captured in that cycle. Every candidate from 1 to number/2 is tested in turn
// by a single serial remainder unit, one dividend bit per cycle; busy stays high
// until the result is returned.
module proper_divisor_sum (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [pds_pkg::NUMBER_WIDTH-1:0]  req_number,
   output logic                              rsp_valid,
   output logic [pds_pkg::SUM_WIDTH-1:0]     rsp_divisor_sum,
   output logic                              rsp_is_perfect
);
   import pds_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_WAIT
   } state_type;

   state_type               state_ff;
   logic [NUMBER_WIDTH-1:0] number_ff;
   logic [NUMBER_WIDTH-1:0] cand_ff;
   logic [ACC_WIDTH-1:0]    acc_ff;
   logic                    rsp_valid_ff;
   logic [SUM_WIDTH-1:0]    rsp_sum_ff;
   logic                    rsp_perfect_ff;

   rem_ctrl_type            rem_ctrl;
   rem_status_type          rem_status;
   logic                    cand_past_half;

   // Shared remainder unit: number mod candidate.
   pds_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (rem_ctrl),
      .dividend (number_ff),
      .divisor  (cand_ff),
      .status   (rem_status)
   );

   // No divisor of n other than n lies above n/2.
   assign cand_past_half = (cand_ff > (number_ff >> 1));
   assign rem_ctrl.start = (state_ff == S_CHECK) && !cand_past_half;

   // Sequencer: state and registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cand_ff      <= '0;
         acc_ff       <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  number_ff <= req_number;
                  cand_ff   <= NUMBER_WIDTH'(1);
                  acc_ff    <= '0;
                  state_ff  <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (cand_past_half) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_sum_ff     <= acc_ff[SUM_WIDTH-1:0];
                  rsp_perfect_ff <= (number_ff != '0) && (acc_ff == ACC_WIDTH'(number_ff));
                  cand_ff        <= '0;
                  state_ff       <= S_IDLE;
               end else begin
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (rem_status.done) begin
                  if (rem_status.is_zero) begin
                     acc_ff <= acc_ff + ACC_WIDTH'(cand_ff);
                  end
                  cand_ff  <= cand_ff + 1'b1;
                  state_ff <= S_CHECK;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_divisor_sum = rsp_sum_ff;
   assign rsp_is_perfect  = rsp_perfect_ff;

   // A result only follows the final candidate check.
   a_rsp_after_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == S_CHECK && state_ff == S_IDLE))
      else $error("result strobe outside end of scan");

   // Zero is never reported perfect.
   a_zero_not_perfect: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_perfect) |-> (number_ff != '0))
      else $error("zero flagged perfect");

   // Candidates in flight never reach the number itself.
   a_cand_proper: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> (cand_ff != '0 && cand_ff < number_ff))
      else $error("candidate outside proper divisor range");

   // The remainder unit is only started from the check state.
   a_start_once: assert property (@(posedge clock) disable iff (reset)
      rem_ctrl.start |=> (state_ff == S_WAIT && !rem_status.done))
      else $error("remainder start out of sequence");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the proper divisor sum block (aliquot sum, perfect flag).
module tb_top;
   import pds_pkg::*;

   // Watchdog limit must cover the longest item (65535); leave plenty of margin.
   localparam int WATCHDOG_LIMIT = 2_500_000;
   localparam int TAIL_CYCLES    = 64;
   localparam int RANDOM_ITEMS   = 100;
   localparam int DIRECTED_ROWS  = 14;

   // One expected result, tagged with the number it belongs to.
   typedef struct packed {
      logic [NUMBER_WIDTH-1:0] number;
      logic [SUM_WIDTH-1:0]    divisor_sum;
      logic                    is_perfect;
   } divisor_result_type;

   // Directed row: a number and, where obvious, its result typed in.
   typedef struct packed {
      logic [NUMBER_WIDTH-1:0] number;
      logic                    has_value;
      logic [SUM_WIDTH-1:0]    divisor_sum;
      logic                    is_perfect;
   } directed_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic [NUMBER_WIDTH-1:0] req_number = '0;
   logic                    busy;
   logic                    rsp_valid;
   logic [SUM_WIDTH-1:0]    rsp_divisor_sum;
   logic                    rsp_is_perfect;

   divisor_result_type next_result = '0;
   divisor_result_type pending_results [$];
   int                 error_count = 0;
   int                 quiet_cycles = 0;

   // Zero, one, primes, perfect numbers, powers of two and the all-ones extreme.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{16'd0,     1'b1, 18'd0,    1'b0},
      '{16'd1,     1'b1, 18'd0,    1'b0},
      '{16'd2,     1'b1, 18'd1,    1'b0},
      '{16'd3,     1'b1, 18'd1,    1'b0},
      '{16'd4,     1'b0, 18'd0,    1'b0},
      '{16'd6,     1'b1, 18'd6,    1'b1},
      '{16'd12,    1'b0, 18'd0,    1'b0},
      '{16'd28,    1'b1, 18'd28,   1'b1},
      '{16'd97,    1'b0, 18'd0,    1'b0},
      '{16'd255,   1'b0, 18'd0,    1'b0},
      '{16'd496,   1'b1, 18'd496,  1'b1},
      '{16'd1024,  1'b0, 18'd0,    1'b0},
      '{16'd8128,  1'b1, 18'd8128, 1'b1},
      '{16'd65535, 1'b0, 18'd0,    1'b0}
   };

   proper_divisor_sum dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_number      (req_number),
      .rsp_valid       (rsp_valid),
      .rsp_divisor_sum (rsp_divisor_sum),
      .rsp_is_perfect  (rsp_is_perfect)
   );

   // 2-unit clock period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Aliquot sum by divisor pairs d and n/d, plus the perfect test on the full sum.
   function automatic divisor_result_type predict_aliquot(input logic [NUMBER_WIDTH-1:0] n);
      longint unsigned total;
      longint unsigned d;
      longint unsigned pair;
      divisor_result_type r;
      total = 0;
      for (d = 1; d * d <= n; d++) begin
         if (n % d == 0) begin
            pair = n / d;
            if (d < n) total += d;
            if (pair != d && pair < n) total += pair;
         end
      end
      r.number      = n;
      r.divisor_sum = SUM_WIDTH'(total);
      r.is_perfect  = (n != 0) && (total == n);
      return r;
   endfunction

   // Present one item and hold it until the block takes it.
   task automatic send_number(input divisor_result_type want);
      req_number  <= want.number;
      next_result <= want;
      start       <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // Random sender gap: each cycle idles with the given percent chance.
   task automatic sender_gap(input int idle_pct);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Hold off until every outstanding item has returned its result.
   task automatic wait_all_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Mostly small numbers keep the run short; some mid-size and perfect ones.
   function automatic logic [NUMBER_WIDTH-1:0] pick_number();
      int unsigned sel;
      int unsigned perfect_pick;
      sel = $urandom_range(99);
      if (sel < 4) begin
         perfect_pick = $urandom_range(2);
         return (perfect_pick == 0) ? 16'd6 : (perfect_pick == 1) ? 16'd28 : 16'd496;
      end
      if (sel < 14) return NUMBER_WIDTH'($urandom_range(256, 1023));
      return NUMBER_WIDTH'($urandom_range(0, 255));
   endfunction

   // Result checking, item tracking and watchdog
   always @(posedge clock) begin : track_items
      divisor_result_type head;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result with none pending: divisor_sum %0d is_perfect %0b",
                        $time, rsp_divisor_sum, rsp_is_perfect);
               error_count++;
            end else begin
               head = pending_results.pop_front();
               if (rsp_divisor_sum !== head.divisor_sum) begin
                  $display("%0t: number %0d divisor_sum expected %0d got %0d",
                           $time, head.number, head.divisor_sum, rsp_divisor_sum);
                  error_count++;
               end
               if (rsp_is_perfect !== head.is_perfect) begin
                  $display("%0t: number %0d is_perfect expected %0b got %0b",
                           $time, head.number, head.is_perfect, rsp_is_perfect);
                  error_count++;
               end
            end
         end
         if (start && busy === 1'b0) pending_results.push_back(next_result);
         if (rsp_valid === 1'b1 || (start && busy === 1'b0)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT - 1) begin
            $display("RESULT: ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Stimulus: directed table, then three random phases
   initial begin : stimulus
      divisor_result_type want;
      int idle_pct;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         want = predict_aliquot(directed_rows[i].number);
         if (directed_rows[i].has_value) begin
            want.divisor_sum = directed_rows[i].divisor_sum;
            want.is_perfect  = directed_rows[i].is_perfect;
         end
         sender_gap(37);
         send_number(want);
      end
      wait_all_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // sender idles 37%, then 59%, then never; drain between phases
         if (i == RANDOM_ITEMS / 3 || i == 2 * RANDOM_ITEMS / 3) wait_all_results();
         if (i < RANDOM_ITEMS / 3) idle_pct = 37;
         else if (i < 2 * RANDOM_ITEMS / 3) idle_pct = 59;
         else idle_pct = 0;
         sender_gap(idle_pct);
         send_number(predict_aliquot(pick_number()));
      end

      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
design/pds_pkg.sv
design/pds_rem_unit.sv
design/proper_divisor_sum.sv
sim/tb_top.sv
